@@ rtl/core/teq_pkg.sv @@
// Shared types and constants for the timed event queue.
package teq_pkg;

	localparam int SLOTS     = 16;
	localparam int SLOT_BITS = 4;
	localparam int GEN_BITS  = 12;
	localparam int QDEPTH    = 2;

	typedef logic [SLOT_BITS-1:0] slot_idx_t;
	typedef logic [GEN_BITS-1:0]  gen_t;

	typedef enum logic [1:0] {
		ACT_POST   = 2'd0,
		ACT_CANCEL = 2'd1,
		ACT_TICK   = 2'd2,
		ACT_NONE   = 2'd3
	} action_t;

	typedef enum logic [2:0] {
		ST_POSTED    = 3'd0,
		ST_FULL      = 3'd1,
		ST_DISCARDED = 3'd2,
		ST_CANCELLED = 3'd3,
		ST_NOMATCH   = 3'd4,
		ST_FIRED     = 3'd5
	} status_t;

	// command handed from the front to the back
	typedef struct packed {
		action_t     action;
		logic [31:0] now;
		logic [31:0] delay;
		logic [31:0] period;
		logic [31:0] tag;
		logic [15:0] cancel_id;
	} cmd_t;

	function automatic gen_t next_gen(input gen_t g);
		gen_t n;
		n = g + gen_t'(1);
		if (n == '0) n = gen_t'(1);
		return n;
	endfunction

	function automatic logic [15:0] make_id(input gen_t g, input slot_idx_t s);
		logic [GEN_BITS+SLOT_BITS-1:0] w;
		w = {g, s};
		return 16'(w);
	endfunction

endpackage

@@ rtl/core/teq_front.sv @@
// Front end: accepts input beats into a short command queue.
module teq_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	input  teq_pkg::cmd_t in_cmd,
	output logic          cmd_valid,
	input  logic          cmd_take,
	output teq_pkg::cmd_t cmd
);
	import teq_pkg::*;

	cmd_t                    mem_q [QDEPTH];
	logic [$clog2(QDEPTH)-1:0] wr_q, rd_q;
	logic [$clog2(QDEPTH):0]   cnt_q;
	logic push, pop;

	assign in_stall  = (cnt_q == ($clog2(QDEPTH)+1)'(QDEPTH));
	assign push      = in_valid && !in_stall && (in_cmd.action != ACT_NONE);
	assign cmd_valid = (cnt_q != '0);
	assign pop       = cmd_valid && cmd_take;
	assign cmd       = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= in_cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + 1'b1;
			if (pop)  rd_q <= rd_q + 1'b1;
			cnt_q <= cnt_q + ($clog2(QDEPTH)+1)'(push) - ($clog2(QDEPTH)+1)'(pop);
		end
	end
endmodule

@@ rtl/core/teq_back.sv @@
// Back end: slot table, post/cancel handling and the tick scan/fire sequencer.
module teq_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cmd_valid,
	output logic          cmd_take,
	input  teq_pkg::cmd_t cmd,
	output logic          out_valid,
	input  logic          out_stall,
	output logic [2:0]    status,
	output logic [15:0]   event_id,
	output logic [31:0]   event_tag,
	output logic          last
);
	import teq_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_SCAN = 4'b0010,
		S_PICK = 4'b0100,
		S_FIRE = 4'b1000
	} state_t;

	state_t state_q;
	logic [SLOTS-1:0] used_q, due_q;
	gen_t        gen_q    [SLOTS];
	logic [31:0] target_q [SLOTS];
	logic [31:0] period_q [SLOTS];
	logic [31:0] tag_q    [SLOTS];
	logic [31:0] order_q  [SLOTS];
	logic [31:0] ocnt_q, now_q;
	slot_idx_t   idx_q, best_q;
	logic        best_ok_q;
	logic [31:0] bkey_q, bage_q;

	logic        ov_q;
	logic [2:0]  st_q;
	logic [15:0] id_q;
	logic [31:0] tg_q;
	logic        last_q;
	logic        out_free;

	assign out_valid = ov_q;
	assign status    = st_q;
	assign event_id  = id_q;
	assign event_tag = tg_q;
	assign last      = last_q;
	assign out_free  = !ov_q || !out_stall;

	// lowest free slot
	slot_idx_t free_s;
	logic      free_ok;
	always_comb begin
		free_s  = '0;
		free_ok = 1'b0;
		for (int i = SLOTS - 1; i >= 0; i--) begin
			if (!used_q[i]) begin
				free_s  = slot_idx_t'(i);
				free_ok = 1'b1;
			end
		end
	end

	slot_idx_t c_s;
	gen_t      c_g;
	logic      c_hit;
	assign c_s   = cmd.cancel_id[SLOT_BITS-1:0];
	assign c_g   = gen_t'(cmd.cancel_id >> SLOT_BITS);
	assign c_hit = used_q[c_s] && (gen_q[c_s] == c_g)
		&& ((32'(c_s) < 32'(SLOTS)))
		&& ((cmd.cancel_id >> SLOT_BITS) == 16'(c_g));

	// scan compare for slot idx_q
	logic [31:0] d_now, key_i, age_i;
	logic        is_due, better;
	assign d_now  = target_q[idx_q] - now_q;
	assign is_due = used_q[idx_q] && (d_now == '0 || d_now[31]);
	assign key_i  = d_now ^ 32'h8000_0000;
	assign age_i  = ocnt_q - order_q[idx_q];
	assign better = !best_ok_q || key_i < bkey_q || (key_i == bkey_q && age_i > bage_q);

	logic last_idx;
	assign last_idx = (32'(idx_q) == 32'(SLOTS - 1));

	assign cmd_take = (state_q == S_IDLE) && cmd_valid && out_free;

	always_ff @(posedge clk) begin
		if (cmd_take && cmd.action == ACT_POST && free_ok && !cmd.delay[31]) begin
			target_q[free_s] <= cmd.now + cmd.delay;
			period_q[free_s] <= cmd.period;
			tag_q[free_s]    <= cmd.tag;
			order_q[free_s]  <= ocnt_q;
		end
		if (state_q == S_FIRE && out_free && !period_q[best_q][31]) begin
			target_q[best_q] <= now_q + period_q[best_q];
			order_q[best_q]  <= ocnt_q;
		end
		if (state_q == S_SCAN || state_q == S_PICK) begin
			if (is_due && due_q[idx_q] && better) begin
				bkey_q <= key_i;
				bage_q <= age_i;
			end
		end
		if (cmd_take) now_q <= cmd.now;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			used_q    <= '0;
			due_q     <= '0;
			ocnt_q    <= '0;
			idx_q     <= '0;
			best_q    <= '0;
			best_ok_q <= 1'b0;
			ov_q      <= 1'b0;
			st_q      <= '0;
			id_q      <= '0;
			tg_q      <= '0;
			last_q    <= 1'b0;
			for (int i = 0; i < SLOTS; i++) gen_q[i] <= gen_t'(1);
		end else begin
			if (ov_q && !out_stall) ov_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (cmd_take) begin
						unique case (cmd.action)
							ACT_POST: begin
								ov_q <= 1'b1; last_q <= 1'b1; tg_q <= '0;
								if (!free_ok) begin
									st_q <= ST_FULL; id_q <= '0;
								end else if (cmd.delay[31]) begin
									st_q <= ST_DISCARDED;
									id_q <= make_id(gen_q[free_s], free_s);
								end else begin
									st_q <= ST_POSTED;
									id_q <= make_id(gen_q[free_s], free_s);
									used_q[free_s] <= 1'b1;
									ocnt_q <= ocnt_q + 32'd1;
								end
							end
							ACT_CANCEL: begin
								ov_q <= 1'b1; last_q <= 1'b1; tg_q <= '0;
								if (c_hit) begin
									st_q <= ST_CANCELLED;
									id_q <= make_id(gen_q[c_s], c_s);
									used_q[c_s] <= 1'b0;
									gen_q[c_s]  <= next_gen(gen_q[c_s]);
								end else begin
									st_q <= ST_NOMATCH;
									id_q <= cmd.cancel_id;
								end
							end
							ACT_TICK: begin
								state_q <= S_SCAN;
								idx_q   <= '0;
								due_q   <= '0;
							end
							default: ;
						endcase
					end
				end
				// mark every due slot once; rearmed slots are not rescanned
				S_SCAN: begin
					due_q[idx_q] <= is_due;
					idx_q <= idx_q + 1'b1;
					if (last_idx) begin
						state_q   <= S_PICK;
						idx_q     <= '0;
						best_ok_q <= 1'b0;
					end
				end
				// one slot a cycle: find the first to fire
				S_PICK: begin
					if (due_q[idx_q] && better) begin
						best_q    <= idx_q;
						best_ok_q <= 1'b1;
					end
					idx_q <= idx_q + 1'b1;
					if (last_idx) begin
						if (best_ok_q || due_q[idx_q]) state_q <= S_FIRE;
						else state_q <= S_IDLE;
					end
				end
				S_FIRE: begin
					if (out_free) begin
						ov_q  <= 1'b1;
						st_q  <= ST_FIRED;
						id_q  <= make_id(gen_q[best_q], best_q);
						tg_q  <= tag_q[best_q];
						due_q[best_q] <= 1'b0;
						last_q <= ((due_q & ~(SLOTS'(1) << best_q)) == '0);
						if (!period_q[best_q][31]) begin
							ocnt_q <= ocnt_q + 32'd1;
						end else begin
							used_q[best_q] <= 1'b0;
							gen_q[best_q]  <= next_gen(gen_q[best_q]);
						end
						if ((due_q & ~(SLOTS'(1) << best_q)) == '0) state_q <= S_IDLE;
						else begin
							state_q   <= S_PICK;
							idx_q     <= '0;
							best_ok_q <= 1'b0;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

@@ rtl/core/timed_event_queue.sv @@
// Top level of the timed event queue: front queue plus slot back end.
//
//  channel  direction  handshake           payload
//  in       in         in_valid/in_stall   action now delay period tag cancel_id
//  out      out        out_valid/out_stall status event_id event_tag last
//
// Post and cancel: queued on the accepting edge, taken by the back end once
// it is idle with its output free, and the single result beat is presented
// from then on. A tick first scans every slot to mark the due ones, then per
// fired event it searches every slot and presents the event; with nothing due
// the search still runs once. Reset clears all slots and the queue at once.
// A stalled result holds the back end; once both command entries are full the
// input stalls.
module timed_event_queue (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  action,
	input  logic [31:0] now,
	input  logic [31:0] delay,
	input  logic [31:0] period,
	input  logic [31:0] tag,
	input  logic [15:0] cancel_id,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  status,
	output logic [15:0] event_id,
	output logic [31:0] event_tag,
	output logic        last
);
	import teq_pkg::*;

	cmd_t in_cmd, cmd;
	logic cmd_valid, cmd_take;

	assign in_cmd = '{action: action_t'(action), now: now, delay: delay,
		period: period, tag: tag, cancel_id: cancel_id};

	teq_front u_front (
		.clk, .arst_n, .in_valid, .in_stall, .in_cmd,
		.cmd_valid, .cmd_take, .cmd
	);

	teq_back u_back (
		.clk, .arst_n, .cmd_valid, .cmd_take, .cmd,
		.out_valid, .out_stall, .status, .event_id, .event_tag, .last
	);
endmodule

@@ tb/timed_event_queue_tb.sv @@
// Self-checking testbench for the timed event queue: post, cancel and tick beats against a predictor.
module timed_event_queue_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import teq_pkg::*;

	typedef struct {
		logic [2:0]  status;
		logic [15:0] event_id;
		logic [31:0] event_tag;
		logic        last;
	} result_t;

	class event_scoreboard;
		bit          used [SLOTS];
		logic [31:0] target [SLOTS];
		logic [31:0] per [SLOTS];
		gen_t        gen [SLOTS];
		logic [31:0] etag [SLOTS];
		logic [31:0] stamp [SLOTS];
		logic [31:0] order_cnt;
		result_t     pending [$];
		int          errors;
		int          checked;
		int          fired;

		function new();
			for (int i = 0; i < SLOTS; i++) begin
				used[i] = 0; gen[i] = gen_t'(1);
				target[i] = 0; per[i] = 0; etag[i] = 0; stamp[i] = 0;
			end
			order_cnt = 0; errors = 0; checked = 0; fired = 0;
		endfunction

		function void push(logic [2:0] st, logic [15:0] id, logic [31:0] tg, logic lst);
			result_t r;
			r.status = st; r.event_id = id; r.event_tag = tg; r.last = lst;
			pending.push_back(r);
		endfunction

		function logic [15:0] id_of(int s);
			return 16'({gen[s], slot_idx_t'(s)});
		endfunction

		function gen_t next_step(gen_t g);
			gen_t n;
			n = g + gen_t'(1);
			return (n == '0) ? gen_t'(1) : n;
		endfunction

		function bit earlier(int a, int b, logic [31:0] tnow);
			logic [31:0] ka, kb;
			ka = (target[a] - tnow) ^ 32'h8000_0000;
			kb = (target[b] - tnow) ^ 32'h8000_0000;
			if (ka != kb) return ka < kb;
			return (order_cnt - stamp[a]) > (order_cnt - stamp[b]);
		endfunction

		function void note_input(logic [1:0] act, logic [31:0] tnow, logic [31:0] dly,
				logic [31:0] prd, logic [31:0] tg, logic [15:0] cid);
			int s, n, j;
			int lst [SLOTS];
			logic [31:0] d;
			gen_t g;
			case (act)
				ACT_POST: begin
					s = SLOTS;
					for (int i = SLOTS - 1; i >= 0; i--) if (!used[i]) s = i;
					if (s == SLOTS) push(ST_FULL, 16'h0, 0, 1);
					else if (dly[31]) push(ST_DISCARDED, id_of(s), 0, 1);
					else begin
						used[s] = 1; target[s] = tnow + dly; per[s] = prd;
						etag[s] = tg; stamp[s] = order_cnt; order_cnt++;
						push(ST_POSTED, id_of(s), 0, 1);
					end
				end
				ACT_CANCEL: begin
					s = cid[SLOT_BITS-1:0];
					g = gen_t'(cid >> SLOT_BITS);
					if (used[s] && gen[s] == g && (cid >> SLOT_BITS) < (1 << GEN_BITS)) begin
						push(ST_CANCELLED, id_of(s), 0, 1);
						used[s] = 0; gen[s] = next_step(gen[s]);
					end else push(ST_NOMATCH, cid, 0, 1);
				end
				ACT_TICK: begin
					n = 0;
					for (int i = 0; i < SLOTS; i++) begin
						d = target[i] - tnow;
						if (used[i] && (d == 0 || d[31])) begin
							j = n;
							while (j > 0 && earlier(i, lst[j-1], tnow)) begin
								lst[j] = lst[j-1]; j--;
							end
							lst[j] = i; n++;
						end
					end
					for (int i = 0; i < n; i++)
						push(ST_FIRED, id_of(lst[i]), etag[lst[i]], i + 1 == n);
					for (int i = 0; i < n; i++) begin
						s = lst[i];
						if (!per[s][31]) begin
							target[s] = tnow + per[s]; stamp[s] = order_cnt; order_cnt++;
						end else begin
							used[s] = 0; gen[s] = next_step(gen[s]);
						end
					end
				end
				default: ;
			endcase
		endfunction

		function void check_result(logic [2:0] st, logic [15:0] id, logic [31:0] tg, logic lst);
			result_t e;
			checked++;
			if (st == ST_FIRED) fired++;
			if (pending.size() == 0) begin
				$display("%0t: unexpected beat status %0d id %h", $realtime, st, id);
				errors++;
				return;
			end
			e = pending.pop_front();
			if (st !== e.status) begin
				$display("%0t: status expected %0d actual %0d", $realtime, e.status, st);
				errors++;
			end
			if (id !== e.event_id) begin
				$display("%0t: event_id expected %h actual %h", $realtime, e.event_id, id);
				errors++;
			end
			if (tg !== e.event_tag) begin
				$display("%0t: event_tag expected %h actual %h", $realtime, e.event_tag, tg);
				errors++;
			end
			if (lst !== e.last) begin
				$display("%0t: last expected %0d actual %0d", $realtime, e.last, lst);
				errors++;
			end
		endfunction
	endclass

	logic        clk, arst_n;
	logic        in_valid, in_stall, out_valid, out_stall, last;
	logic [1:0]  action;
	logic [31:0] now, delay, period, tag, event_tag;
	logic [15:0] cancel_id, event_id;
	logic [2:0]  status;

	event_scoreboard sb;
	logic [31:0] clock_now;
	logic [15:0] ids [$];
	bit          hold_off;
	int          idle_cycles;
	int          beats_in;

	timed_event_queue u_top (.*);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	initial begin
		arst_n = 0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1;
	end

	// monitor: sample both channels on the rising edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				sb.note_input(action, now, delay, period, tag, cancel_id);
				beats_in++;
			end
			if (out_valid && !out_stall)
				sb.check_result(status, event_id, event_tag, last);
			if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
			else idle_cycles++;
			if (idle_cycles > 20000) begin
				$display("simulation failed");
				$finish;
			end
			if (out_valid && !out_stall && status == ST_POSTED) ids.push_back(event_id);
		end
	end

	// receiver stall pattern with one long hold-off
	initial begin
		int mode;
		out_stall = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_off) out_stall = 1;
			else begin
				mode = (beats_in / 40) % 3;
				case (mode)
					0: out_stall = 0;
					1: out_stall = ($urandom_range(0, 3) == 0);
					default: out_stall = ($urandom_range(0, 1) == 0);
				endcase
			end
		end
	end

	task automatic send(logic [1:0] a, logic [31:0] t, logic [31:0] d, logic [31:0] p,
			logic [31:0] tg, logic [15:0] cid);
		action = a; now = t; delay = d; period = p; tag = tg; cancel_id = cid;
		in_valid = 1;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		@(negedge clk);
		in_valid = 0;
	endtask

	task automatic gap();
		if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 6)) @(negedge clk);
	endtask

	task automatic random_item();
		int k;
		logic [31:0] d;
		logic [15:0] cid;
		k = $urandom_range(0, 99);
		if (k < 45) begin
			d = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 40);
			send(ACT_POST, clock_now, d,
				($urandom_range(0, 2) == 0) ? $urandom_range(0, 30) : $urandom | 32'h8000_0000,
				$urandom, 16'($urandom));
		end else if (k < 65) begin
			if (ids.size() > 0 && $urandom_range(0, 3) != 0)
				cid = ids[$urandom_range(0, ids.size() - 1)];
			else cid = 16'($urandom);
			send(ACT_CANCEL, $urandom, $urandom, $urandom, $urandom, cid);
		end else if (k < 97) begin
			clock_now += $urandom_range(0, 25);
			send(ACT_TICK, clock_now, $urandom, $urandom, $urandom, 16'($urandom));
		end else
			send(ACT_NONE, $urandom, $urandom, $urandom, $urandom, 16'($urandom));
	endtask

	initial begin
		sb = new();
		in_valid = 0; action = ACT_NONE; now = 0; delay = 0; period = 0; tag = 0;
		cancel_id = 0; hold_off = 0; idle_cycles = 0; beats_in = 0;
		clock_now = 32'hFFFF_FFF0;
		@(posedge arst_n);
		@(negedge clk);
		// directed: extremes, discard, wrap of target, periodic with zero period
		send(ACT_POST, clock_now, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);
		send(ACT_POST, clock_now, 32'h8000_0000, 0, 32'h1234, 0);
		send(ACT_POST, clock_now, 32'd20, 32'd0, 32'hA5A5_5A5A, 0);
		send(ACT_POST, clock_now, 32'd20, 32'h8000_0000, 32'h0, 0);
		send(ACT_POST, clock_now, 32'd0, 32'h7FFF_FFFF, 32'h1, 0);
		send(ACT_TICK, clock_now, 0, 0, 0, 0);
		send(ACT_TICK, clock_now + 32'd20, 0, 0, 0, 0);
		send(ACT_CANCEL, 0, 0, 0, 0, 16'hFFFF);
		send(ACT_CANCEL, 0, 0, 0, 0, 16'h0010);
		send(ACT_CANCEL, 0, 0, 0, 0, 16'h0010);
		send(ACT_NONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF);
		for (int i = 0; i < 17; i++)
			send(ACT_POST, clock_now, 32'd5, 32'hFFFF_FFFF, i, 0);
		send(ACT_POST, clock_now, 32'hFFFF_FFFF, 0, 0, 0);
		clock_now += 32'd5;
		send(ACT_TICK, clock_now, 0, 0, 0, 0);
		// long receiver hold-off while beats keep coming
		fork
			begin
				hold_off = 1;
				repeat (600) @(negedge clk);
				hold_off = 0;
			end
			for (int i = 0; i < 10; i++) random_item();
		join
		for (int i = 0; i < 80; i++) begin
			random_item();
			gap();
		end
		while (sb.pending.size() > 0) @(negedge clk);
		repeat (400) @(negedge clk);
		$display("covered %0d input beats, %0d result beats, %0d fired events",
			beats_in, sb.checked, sb.fired);
		if (sb.errors == 0 && sb.pending.size() == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end
endmodule
